FILE: rtl/r2y420_pkg.sv
// Shared types and constants for the 2x2 RGB to YCbCr 4:2:0 converter.
// Holds the input and output word structs and the Q16/Q18 coefficients.
// No dependencies.
package r2y420_pkg;

	// One 2x2 block of BGR pixels, first row then second row.
	typedef struct packed {
		logic [7:0] first_left_blue;
		logic [7:0] first_left_green;
		logic [7:0] first_left_red;
		logic [7:0] first_right_blue;
		logic [7:0] first_right_green;
		logic [7:0] first_right_red;
		logic [7:0] second_left_blue;
		logic [7:0] second_left_green;
		logic [7:0] second_left_red;
		logic [7:0] second_right_blue;
		logic [7:0] second_right_green;
		logic [7:0] second_right_red;
	} pix_t;

	// Four luma bytes and the shared chroma pair.
	typedef struct packed {
		logic [7:0] luma_first_left;
		logic [7:0] luma_first_right;
		logic [7:0] luma_second_left;
		logic [7:0] luma_second_right;
		logic [7:0] blue_difference;
		logic [7:0] red_difference;
	} ycc_t;

	// Luma coefficients in Q16, offset 16.5 in Q16.
	localparam logic [15:0] LUMA_CB     = 16'd6423;
	localparam logic [15:0] LUMA_CG     = 16'd33030;
	localparam logic [15:0] LUMA_CR     = 16'd16843;
	localparam logic [23:0] LUMA_OFFSET = 24'd1081344;
	localparam logic [7:0]  LUMA_MIN    = 8'd16;
	localparam logic [7:0]  LUMA_MAX    = 8'd235;

	// Chroma coefficient magnitudes in Q16; the divide by four is folded
	// into the final shift of 18. Offset 128.5 in Q18.
	localparam logic [14:0] CB_CB_MAG   = 15'd28770;
	localparam logic [14:0] CB_CG_MAG   = 15'd19071;
	localparam logic [14:0] CB_CR_MAG   = 15'd9699;
	localparam logic [14:0] CR_CB_MAG   = 15'd4653;
	localparam logic [14:0] CR_CG_MAG   = 15'd24117;
	localparam logic [14:0] CR_CR_MAG   = 15'd28770;
	localparam logic signed [26:0] CHROMA_OFFSET = 27'sd33685504;
	localparam logic [7:0]  CHROMA_MIN  = 8'd16;
	localparam logic [7:0]  CHROMA_MAX  = 8'd240;

	// Take the integer part of a Q16 luma sum and clamp it.
	function automatic logic [7:0] luma_clamp(input logic [23:0] acc);
		logic [7:0] v;
		v = acc[23:16];
		if (v < LUMA_MIN) begin
			return LUMA_MIN;
		end else if (v > LUMA_MAX) begin
			return LUMA_MAX;
		end
		return v;
	endfunction

	// Take the integer part of a signed Q18 chroma sum and clamp it.
	// A negative sum is treated as zero, which clamps up to the minimum.
	function automatic logic [7:0] chroma_clamp(input logic signed [26:0] acc);
		logic [8:0] v;
		v = acc[26:18];
		if (acc[26]) begin
			return CHROMA_MIN;
		end else if (v < 9'(CHROMA_MIN)) begin
			return CHROMA_MIN;
		end else if (v > 9'(CHROMA_MAX)) begin
			return CHROMA_MAX;
		end
		return v[7:0];
	endfunction

endpackage

FILE: rtl/rgb_to_ycbcr420_block.sv
// Top level of the 2x2 BGR to BT.601 limited-range YCbCr 4:2:0 converter.
// Four-stage pipeline with a stall chain that runs back through every stage.
// Depends on r2y420_pkg.
//
// Usage: the pixel channel (pix_valid, pix_stall, pix) carries one word per
// 2x2 block: three bytes for each of the four pixels. The result channel
// (ycc_valid, ycc_stall, ycc) carries one word per block: four luma bytes
// and one Cb and one Cr byte shared by the block.
// A word is taken at a rising edge where valid is high and stall is low.
// The accepting edge loads stage 1; the word then moves on through stages
// 2, 3 and 4, and ycc_valid rises when it reaches stage 4. The block takes
// one word every cycle while pix_stall is low. The four register stages
// hold: luma products and chroma channel sums, luma sums and chroma
// products, luma clamp and chroma sums, chroma clamp. The last stage is
// the output register.
// Each stage moves whenever it is empty or the stage after it moves, so
// bubbles close up. pix_stall rises only when all four stages hold a word
// and the receiver stalls; a stalled result word holds its value.
// Reset clears every stage's valid bit; payload registers are not reset.
module rgb_to_ycbcr420_block (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  r2y420_pkg::pix_t  pix,
	output logic              ycc_valid,
	input  logic              ycc_stall,
	output r2y420_pkg::ycc_t  ycc
);

	// Per-pixel channel bytes, in the order left-first, right-first,
	// left-second, right-second.
	logic [7:0] blue  [4];
	logic [7:0] green [4];
	logic [7:0] red   [4];

	assign blue[0]  = pix.first_left_blue;
	assign green[0] = pix.first_left_green;
	assign red[0]   = pix.first_left_red;
	assign blue[1]  = pix.first_right_blue;
	assign green[1] = pix.first_right_green;
	assign red[1]   = pix.first_right_red;
	assign blue[2]  = pix.second_left_blue;
	assign green[2] = pix.second_left_green;
	assign red[2]   = pix.second_left_red;
	assign blue[3]  = pix.second_right_blue;
	assign green[3] = pix.second_right_green;
	assign red[3]   = pix.second_right_red;

	// Stage valid bits and the backward move signals.
	logic v_s1, v_s2, v_s3, v_s4;
	logic mv1, mv2, mv3, mv4;

	// A stage may load when it is empty or its word leaves this cycle.
	assign mv4 = !v_s4 || !ycc_stall;
	assign mv3 = !v_s3 || mv4;
	assign mv2 = !v_s2 || mv3;
	assign mv1 = !v_s1 || mv2;
	assign pix_stall = !mv1;

	// Stage 1: luma products for every pixel, chroma channel sums.
	logic [23:0] lpb_s1 [4];
	logic [23:0] lpg_s1 [4];
	logic [23:0] lpr_s1 [4];
	logic [9:0]  sb_s1, sg_s1, sr_s1;

	// Stage 2: luma sums with offset, chroma product magnitudes.
	logic [23:0] lacc_s2 [4];
	logic [24:0] cbb_s2, cbg_s2, cbr_s2;
	logic [24:0] crb_s2, crg_s2, crr_s2;

	// Stage 3: clamped luma, signed chroma sums.
	logic [7:0]         luma_s3 [4];
	logic signed [26:0] cb_acc_s3, cr_acc_s3;

	// Stage 4: the output word.
	r2y420_pkg::ycc_t ycc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (mv1) begin
				v_s1 <= pix_valid;
			end
			if (mv2) begin
				v_s2 <= v_s1;
			end
			if (mv3) begin
				v_s3 <= v_s2;
			end
			if (mv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1 payload. Each luma product is 16 by 8 bits; each channel sum
	// covers the four pixels and fits ten bits.
	always_ff @(posedge clk) begin
		if (mv1 && pix_valid) begin
			for (int i = 0; i < 4; i++) begin
				lpb_s1[i] <= 24'(r2y420_pkg::LUMA_CB * blue[i]);
				lpg_s1[i] <= 24'(r2y420_pkg::LUMA_CG * green[i]);
				lpr_s1[i] <= 24'(r2y420_pkg::LUMA_CR * red[i]);
			end
			sb_s1 <= 10'(blue[0])  + 10'(blue[1])  + 10'(blue[2])  + 10'(blue[3]);
			sg_s1 <= 10'(green[0]) + 10'(green[1]) + 10'(green[2]) + 10'(green[3]);
			sr_s1 <= 10'(red[0])   + 10'(red[1])   + 10'(red[2])   + 10'(red[3]);
		end
	end

	// Stage 2 payload. The luma sum peaks just under 2^24, so 24 bits hold
	// it without wrap.
	always_ff @(posedge clk) begin
		if (mv2 && v_s1) begin
			for (int i = 0; i < 4; i++) begin
				lacc_s2[i] <= lpb_s1[i] + lpg_s1[i] + lpr_s1[i] + r2y420_pkg::LUMA_OFFSET;
			end
			cbb_s2 <= 25'(r2y420_pkg::CB_CB_MAG * sb_s1);
			cbg_s2 <= 25'(r2y420_pkg::CB_CG_MAG * sg_s1);
			cbr_s2 <= 25'(r2y420_pkg::CB_CR_MAG * sr_s1);
			crb_s2 <= 25'(r2y420_pkg::CR_CB_MAG * sb_s1);
			crg_s2 <= 25'(r2y420_pkg::CR_CG_MAG * sg_s1);
			crr_s2 <= 25'(r2y420_pkg::CR_CR_MAG * sr_s1);
		end
	end

	// Stage 3 payload. Chroma products carry their signs here: Cb adds
	// blue and subtracts green and red, Cr adds red and subtracts the rest.
	always_ff @(posedge clk) begin
		if (mv3 && v_s2) begin
			for (int i = 0; i < 4; i++) begin
				luma_s3[i] <= r2y420_pkg::luma_clamp(lacc_s2[i]);
			end
			cb_acc_s3 <= $signed({2'b00, cbb_s2}) - $signed({2'b00, cbg_s2})
				- $signed({2'b00, cbr_s2}) + r2y420_pkg::CHROMA_OFFSET;
			cr_acc_s3 <= $signed({2'b00, crr_s2}) - $signed({2'b00, crb_s2})
				- $signed({2'b00, crg_s2}) + r2y420_pkg::CHROMA_OFFSET;
		end
	end

	// Stage 4 payload: the output register.
	always_ff @(posedge clk) begin
		if (mv4 && v_s3) begin
			ycc_s4.luma_first_left   <= luma_s3[0];
			ycc_s4.luma_first_right  <= luma_s3[1];
			ycc_s4.luma_second_left  <= luma_s3[2];
			ycc_s4.luma_second_right <= luma_s3[3];
			ycc_s4.blue_difference   <= r2y420_pkg::chroma_clamp(cb_acc_s3);
			ycc_s4.red_difference    <= r2y420_pkg::chroma_clamp(cr_acc_s3);
		end
	end

	assign ycc_valid = v_s4;
	assign ycc       = ycc_s4;

	// The input stalls only when the whole pipeline is full and blocked.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && ycc_stall))
		else $error("input stalled while a stage was free");

	// A word that is blocked at the output is still there next cycle.
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && ycc_stall) |=> (v_s4 && $stable(ycc_s4)))
		else $error("blocked result word lost or changed");

	// Luma of every pixel lies within the limited range.
	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (ycc_s4.luma_first_left >= 8'd16 && ycc_s4.luma_first_left <= 8'd235
			&& ycc_s4.luma_first_right >= 8'd16 && ycc_s4.luma_first_right <= 8'd235
			&& ycc_s4.luma_second_left >= 8'd16 && ycc_s4.luma_second_left <= 8'd235
			&& ycc_s4.luma_second_right >= 8'd16 && ycc_s4.luma_second_right <= 8'd235))
		else $error("luma out of range");

	// The chroma pair lies within the limited range.
	a_chroma_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (ycc_s4.blue_difference >= 8'd16 && ycc_s4.blue_difference <= 8'd240
			&& ycc_s4.red_difference >= 8'd16 && ycc_s4.red_difference <= 8'd240))
		else $error("chroma out of range");

endmodule
